[sv/suffix_automaton_builder_unit_defines.svh]
// Assertion macros for the suffix automaton builder RTL.
// Depends on nothing; included by the top level.
`ifndef SUFFIX_AUTOMATON_BUILDER_UNIT_DEFINES_SVH
`define SUFFIX_AUTOMATON_BUILDER_UNIT_DEFINES_SVH
// Implication checked on every clock edge outside reset.
`define SAB_ASSERT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
// Implication whose consequence is checked in the cycle after the antecedent.
`define SAB_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`endif

[sv/sab_pkg.sv]
// Package for the suffix automaton builder: sizes, widths and state codes.
// Depends on nothing.
package sab_pkg;
	localparam int MaxStates = 1024;
	localparam int Alphabet  = 26;
	localparam int SW        = $clog2(MaxStates);
	localparam int CW        = $clog2(Alphabet);
	localparam int TW        = $clog2(MaxStates * Alphabet);

	typedef logic [SW-1:0] st_t;

	typedef enum logic [11:0] {
		S_IDLE   = 12'b000000000001,
		S_ALLOC  = 12'b000000000010,
		S_CLR    = 12'b000000000100,
		S_WRD    = 12'b000000001000,
		S_WCHK   = 12'b000000010000,
		S_QCHK   = 12'b000000100000,
		S_CPYRD  = 12'b000001000000,
		S_CPYWR  = 12'b000010000000,
		S_RRD    = 12'b000100000000,
		S_RCHK   = 12'b001000000000,
		S_FIN    = 12'b010000000000,
		S_RINIT  = 12'b100000000000
	} fsm_t;
endpackage

[sv/suffix_automaton_builder_unit.sv]
// Suffix automaton builder top level: control sequencer and the state memories.
// Depends on sab_pkg and suffix_automaton_builder_unit_defines.svh.
`include "suffix_automaton_builder_unit_defines.svh"

// The block takes one symbol per request while busy is low and builds the
// suffix automaton of the text received so far. The work on a symbol goes
// in steps: allocate the new state, clear its row entry by entry, walk the
// suffix links and finish. When the walk finds a transition, the state it
// leads to is fetched; if that state is cloned, its row is copied entry by
// entry and each transition that led to it is redirected to the clone.
// After reset the block clears the root row with busy high. The result of
// each request appears for exactly one cycle with done high; it cannot be
// held off, so it must be captured when done is seen. A symbol of ALPHABET
// or above is reported without change in the cycle after it is taken, and
// once fewer than two free states remain every symbol is ignored in the
// same way with table_full set.
module suffix_automaton_builder_unit import sab_pkg::*; (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	input  logic [4:0]    symbol,
	output logic          done,
	output logic [SW-1:0] last_state,
	output logic [SW-1:0] state_count,
	output logic [SW-1:0] text_length,
	output logic          clone_made,
	output logic          table_full
);
	// Memories: length and link packed per state, one transition per state
	// and symbol.
	logic [2*SW-1:0] node_mem [MaxStates];
	logic [SW-1:0]   tr_mem   [MaxStates*Alphabet];

	fsm_t          st_q;
	st_t           used_q, last_q, cur_q, p_q, q_q, cl_q;
	logic [SW-1:0] curlen_q, plen_q, qlen_q;
	logic [CW-1:0] c_q, k_q;
	logic          clone_q;
	logic [SW-1:0] tr_rd_q;
	logic [2*SW-1:0] node_rd_q;
	logic [SW-1:0] len_rd, lnk_rd;

	// Combinational memory request.
	logic          tr_we, node_we;
	logic [TW-1:0] tr_wa, tr_ra;
	logic [SW-1:0] tr_wd;
	logic [2*SW-1:0] node_wd;
	st_t           node_wa, node_ra;

	function automatic logic [TW-1:0] taddr(st_t s, logic [CW-1:0] c);
		taddr = TW'(s) * TW'(Alphabet) + TW'(c);
	endfunction

	always_ff @(posedge clk) begin
		if (tr_we) tr_mem[tr_wa] <= tr_wd;
		if (node_we) node_mem[node_wa] <= node_wd;
		tr_rd_q   <= tr_mem[tr_ra];
		node_rd_q <= node_mem[node_ra];
	end
	assign len_rd = node_rd_q[2*SW-1:SW];
	assign lnk_rd = node_rd_q[SW-1:0];

	logic last_k;
	assign last_k = (k_q == CW'(Alphabet - 1));

	always_comb begin
		tr_we = 1'b0; tr_wa = taddr(p_q, c_q); tr_wd = cur_q;
		tr_ra = taddr(p_q, c_q);
		node_we = 1'b0; node_wa = cur_q; node_wd = {curlen_q, SW'(0)};
		node_ra = p_q;
		unique case (st_q)
			// Fetch the length of the last state while waiting for a symbol.
			S_IDLE: node_ra = last_q;
			S_RINIT: begin
				tr_we = 1'b1; tr_wa = taddr(st_t'(1), k_q); tr_wd = '0;
				node_we = 1'b1; node_wa = st_t'(1); node_wd = '0;
			end
			S_CLR: begin
				tr_we = 1'b1; tr_wa = taddr(cur_q, k_q); tr_wd = '0;
				node_we = 1'b1;
			end
			S_WCHK: begin
				// Missing transition: point it at the new state.
				if (tr_rd_q == '0) tr_we = 1'b1;
			end
			S_QCHK: node_ra = q_q;
			S_CPYRD: begin
				tr_ra = taddr(q_q, k_q);
				node_ra = q_q;
			end
			S_CPYWR: begin
				tr_we = 1'b1; tr_wa = taddr(cl_q, k_q); tr_wd = tr_rd_q;
				// The clone takes the link of q first; q is relinked to the
				// clone on the next entry so that one write port serves both.
				if (k_q == '0) begin
					node_we = 1'b1; node_wa = cl_q; node_wd = {plen_q + SW'(1), lnk_rd};
				end else if (k_q == CW'(1)) begin
					node_we = 1'b1; node_wa = q_q; node_wd = {qlen_q, cl_q};
				end
				tr_ra = taddr(q_q, k_q + CW'(1));
			end
			S_RCHK: begin
				if (tr_rd_q == q_q) begin
					tr_we = 1'b1; tr_wd = cl_q;
				end
			end
			S_FIN: begin
				node_we = 1'b1;
				node_wd = {curlen_q, clone_q ? cl_q : (p_q == '0 ? st_t'(1) : q_q)};
			end
			default: ;
		endcase
	end

	logic full;
	assign full = ({1'b0, used_q} + (SW+1)'(2)) > (SW+1)'(MaxStates - 1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= S_RINIT; used_q <= st_t'(1); last_q <= st_t'(1);
			k_q <= '0; done <= 1'b0; clone_q <= 1'b0; table_full <= 1'b0;
			clone_made <= 1'b0; last_state <= st_t'(1); state_count <= st_t'(1);
			text_length <= '0;
		end else begin
			done <= 1'b0;
			unique case (st_q)
				S_RINIT: begin
					k_q <= k_q + CW'(1);
					if (last_k) begin k_q <= '0; st_q <= S_IDLE; end
				end
				S_IDLE: begin
					if (start) begin
						clone_q <= 1'b0;
						c_q <= symbol[CW-1:0];
						p_q <= last_q;
						if (full || symbol >= 5'(Alphabet)) begin
							done <= 1'b1; table_full <= full; clone_made <= 1'b0;
						end else st_q <= S_ALLOC;
					end
				end
				S_ALLOC: begin
					// len_rd holds the length of the last state.
					cur_q <= used_q + st_t'(1); used_q <= used_q + st_t'(1);
					k_q <= '0; st_q <= S_CLR;
				end
				S_CLR: begin
					k_q <= k_q + CW'(1);
					if (last_k) begin k_q <= '0; st_q <= S_WRD; end
				end
				S_WRD: st_q <= (p_q == '0) ? S_FIN : S_WCHK;
				S_WCHK: begin
					plen_q <= len_rd;
					if (tr_rd_q == '0) begin
						p_q <= lnk_rd; st_q <= S_WRD;
					end else begin
						q_q <= tr_rd_q; st_q <= S_QCHK;
					end
				end
				S_QCHK: st_q <= S_CPYRD;
				S_CPYRD: begin
					if (len_rd == plen_q + SW'(1)) st_q <= S_FIN;
					else begin
						cl_q <= used_q + st_t'(1); used_q <= used_q + st_t'(1);
						qlen_q <= len_rd;
						clone_q <= 1'b1; k_q <= '0; st_q <= S_CPYWR;
					end
				end
				S_CPYWR: begin
					k_q <= k_q + CW'(1);
					if (last_k) begin k_q <= '0; st_q <= S_RRD; end
				end
				S_RRD: st_q <= S_RCHK;
				S_RCHK: begin
					if (tr_rd_q == q_q) begin
						p_q <= lnk_rd;
						st_q <= (lnk_rd == '0) ? S_FIN : S_RRD;
					end else st_q <= S_FIN;
				end
				S_FIN: begin
					last_q <= cur_q; last_state <= cur_q;
					state_count <= used_q; text_length <= curlen_q;
					clone_made <= clone_q; table_full <= 1'b0;
					done <= 1'b1; st_q <= S_IDLE;
				end
				default: st_q <= S_IDLE;
			endcase
			if (st_q == S_IDLE && start && (full || symbol >= 5'(Alphabet))) begin
				last_state <= last_q; state_count <= used_q; text_length <= curlen_q;
			end
		end
	end

	// Text length of the root before any symbol: curlen_q must read zero.
	// It is a payload register, so clear it while the root row is cleared.
	always_ff @(posedge clk) begin
		if (st_q == S_RINIT) curlen_q <= '0;
		else if (st_q == S_ALLOC) curlen_q <= len_rd + SW'(1);
	end

	assign busy = (st_q != S_IDLE);

	`SAB_ASSERT(a_done_idle, done, st_q == S_IDLE)
	`SAB_ASSERT_NEXT(a_fin_done, st_q == S_FIN, done)
	`SAB_ASSERT(a_used_grows, done && !table_full && clone_made, state_count >= st_t'(3))
	`SAB_ASSERT_NEXT(a_start_busy, start && !busy && !full && symbol < 5'(Alphabet), busy)
endmodule
